FILE: design/ps2_mouse_packet_cursor_tracker_core_macros.svh
// Assertion macros used by the checker file.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2M_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define PS2M_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: design/ps2m_pkg.sv
package ps2m_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BOUND_W  = 16;
  localparam int unsigned CURSOR_W = 16;
  localparam int unsigned BTN_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BOUND_W-1:0] BOUND_X_RESET = 16'd1280;
  localparam logic [BOUND_W-1:0] BOUND_Y_RESET = 16'd800;
  localparam longint unsigned POS_X_RESET = 64'd640;
  localparam longint unsigned POS_Y_RESET = 64'd400;

  localparam int unsigned SYNC_BIT   = 3;
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;
  localparam logic [BYTE_W-1:0] OVF_MASK = 8'hC0;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [BOUND_W-1:0]  bound_t;
  typedef logic [CURSOR_W-1:0] cursor_t;
  typedef logic [BTN_W-1:0]    btn_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_X = 1'd0,
    CFG_BOUND_Y = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_APPLIED = 2'd2,
    ST_DROPPED = 2'd3
  } status_e;

endpackage

FILE: design/ps2m_byte_if.sv
interface ps2m_byte_if;
  import ps2m_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: design/ps2m_cursor_if.sv
interface ps2m_cursor_if;
  import ps2m_pkg::*;

  logic    valid;
  logic    ready;
  cursor_t cursor_x;
  cursor_t cursor_y;
  btn_t    button_bits;
  status_e status;

  modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                  output status, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input button_bits,
                input status, output ready);
endinterface

FILE: design/ps2_mouse_packet_cursor_tracker_core.sv
// Channel   | Dir | Word
// ----------+-----+-----------------------------------------------
// in_ch     | in  | rx_byte, one byte from the mouse data port
// out_ch    | out | cursor_x, cursor_y, button_bits, status
// cfg_*     | in  | write of bound_x (index 0) or bound_y (index 1)
//
// One word in, one word out; a new byte is taken every cycle while the output is not stalled.
// A byte passes through the input register, then decode/add/clamp into the result register.
// Reset clears the packet state, centers the cursor and loads the default bounds.
// A stalled output holds its word; the input register still fills behind it.
module ps2_mouse_packet_cursor_tracker_core #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ps2m_pkg::cfg_idx_t cfg_idx_i,
  input  ps2m_pkg::bound_t   cfg_data_i,
  ps2m_byte_if.sink          in_ch,
  ps2m_cursor_if.source      out_ch
);
  import ps2m_pkg::*;

  localparam int unsigned WIDE_W = 34;
  localparam logic [WIDE_W-1:0] CoordMax = (WIDE_W'(1) << COORD_WIDTH) - WIDE_W'(1);
  localparam logic [COORD_WIDTH-1:0] PosXInit =
    (WIDE_W'(POS_X_RESET) > CoordMax) ? COORD_WIDTH'(CoordMax) : COORD_WIDTH'(POS_X_RESET);
  localparam logic [COORD_WIDTH-1:0] PosYInit =
    (WIDE_W'(POS_Y_RESET) > CoordMax) ? COORD_WIDTH'(CoordMax) : COORD_WIDTH'(POS_Y_RESET);

  typedef logic [COORD_WIDTH-1:0] coord_t;

  function automatic coord_t move_clamp(coord_t pos, logic signed [9:0] delta, bound_t bound);
    logic signed [WIDE_W-1:0] v;
    bound_t                   b;
    logic [WIDE_W-1:0]        hi;
    coord_t                   res;
    b  = (bound == '0) ? bound_t'(1) : bound;
    hi = WIDE_W'(b - bound_t'(1));
    if (hi > CoordMax) begin
      hi = CoordMax;
    end
    v = $signed(WIDE_W'(pos)) + WIDE_W'(delta);
    if (v < 0) begin
      res = '0;
    end else if ($unsigned(v) > hi) begin
      res = COORD_WIDTH'(hi);
    end else begin
      res = COORD_WIDTH'($unsigned(v));
    end
    return res;
  endfunction

  bound_t  bound_x_q, bound_y_q;
  logic    in_v_q;
  byte_t   byte_q;
  logic    out_v_q;
  logic [1:0] idx_q, idx_d;
  byte_t   pkt0_q, pkt0_d, pkt1_q, pkt1_d;
  coord_t  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  btn_t    btn_q, btn_d;
  status_e st_d, st_q;
  logic    advance;
  logic signed [9:0] dx, dy, neg_dy;

  assign advance     = in_v_q && (!out_v_q || out_ch.ready);
  assign in_ch.ready = !in_v_q || advance;

  assign dx     = {pkt0_q[X_SIGN_BIT], pkt0_q[X_SIGN_BIT], pkt1_q};
  assign dy     = {pkt0_q[Y_SIGN_BIT], pkt0_q[Y_SIGN_BIT], byte_q};
  assign neg_dy = -dy;

  always_comb begin
    idx_d   = idx_q;
    pkt0_d  = pkt0_q;
    pkt1_d  = pkt1_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    btn_d   = btn_q;
    st_d    = ST_STORED;
    if (idx_q == 2'd0 && !byte_q[SYNC_BIT]) begin
      st_d = ST_SKIPPED;
    end else if (idx_q < 2'd2) begin
      if (idx_q[0]) begin
        pkt1_d = byte_q;
      end else begin
        pkt0_d = byte_q;
      end
      idx_d = idx_q + 2'd1;
    end else begin
      idx_d = 2'd0;
      if ((pkt0_q & OVF_MASK) != '0) begin
        st_d = ST_DROPPED;
      end else begin
        pos_x_d = move_clamp(pos_x_q, dx, bound_x_q);
        pos_y_d = move_clamp(pos_y_q, neg_dy, bound_y_q);
        btn_d   = pkt0_q[BTN_W-1:0];
        st_d    = ST_APPLIED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_x_q <= BOUND_X_RESET;
      bound_y_q <= BOUND_Y_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOUND_X: bound_x_q <= cfg_data_i;
        CFG_BOUND_Y: bound_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      idx_q   <= 2'd0;
      pkt0_q  <= '0;
      pkt1_q  <= '0;
      pos_x_q <= PosXInit;
      pos_y_q <= PosYInit;
      btn_q   <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_q <= in_ch.valid;
      end
      if (advance) begin
        out_v_q <= 1'b1;
        idx_q   <= idx_d;
        pkt0_q  <= pkt0_d;
        pkt1_q  <= pkt1_d;
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        btn_q   <= btn_d;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_q <= in_ch.rx_byte;
    end
    if (advance) begin
      st_q <= st_d;
    end
  end

  assign out_ch.valid       = out_v_q;
  assign out_ch.cursor_x    = CURSOR_W'(32'(pos_x_q));
  assign out_ch.cursor_y    = CURSOR_W'(32'(pos_y_q));
  assign out_ch.button_bits = btn_q;
  assign out_ch.status      = st_q;

endmodule

FILE: design/ps2m_checker.sv
`include "ps2_mouse_packet_cursor_tracker_core_macros.svh"

module ps2m_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input ps2m_pkg::cfg_idx_t cfg_idx_i,
  input ps2m_pkg::bound_t   cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ps2m_pkg::cursor_t  cursor_x_i,
  input ps2m_pkg::cursor_t  cursor_y_i,
  input ps2m_pkg::btn_t     button_bits_i,
  input ps2m_pkg::status_e  status_i
);
  import ps2m_pkg::*;

  bound_t bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bx_q <= BOUND_X_RESET;
      by_q <= BOUND_Y_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOUND_X: bx_q <= cfg_data_i;
        CFG_BOUND_Y: by_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  `PS2M_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(cursor_x_i) && $stable(cursor_y_i) && $stable(button_bits_i) && $stable(status_i))
  `PS2M_ASSERT_IMPL(a_in_stall_cause, clk_i, rst_ni, in_valid_i && !in_ready_i, out_valid_i && !out_ready_i)
  `PS2M_ASSERT_IMPL(a_x_in_bound, clk_i, rst_ni, out_valid_i && status_i == ST_APPLIED, cursor_x_i < bx_q || cursor_x_i == '0)
  `PS2M_ASSERT_IMPL(a_y_in_bound, clk_i, rst_ni, out_valid_i && status_i == ST_APPLIED, cursor_y_i < by_q || cursor_y_i == '0)

endmodule

bind ps2_mouse_packet_cursor_tracker_core ps2m_checker u_ps2m_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_data_i    (cfg_data_i),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .cursor_x_i    (out_ch.cursor_x),
  .cursor_y_i    (out_ch.cursor_y),
  .button_bits_i (out_ch.button_bits),
  .status_i      (out_ch.status)
);

FILE: bench/ps2m_cursor_scoreboard.sv
`timescale 1ns / 1ps
module ps2m_cursor_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ps2m_pkg::cfg_idx_t cfg_idx_i,
  input  ps2m_pkg::bound_t   cfg_data_i,
  ps2m_byte_if               byte_mon,
  ps2m_cursor_if             cursor_mon,
  output int                 err_cnt_o,
  output int                 outstanding_o,
  output int                 words_o,
  output int                 applied_o,
  output int                 dropped_o
);
  import ps2m_pkg::*;

  typedef struct {
    cursor_t x;
    cursor_t y;
    btn_t    btn;
    status_e st;
  } cursor_word_t;

  logic [1:0]   byte_idx;
  byte_t        pkt_buf [2];
  cursor_t      pos_x;
  cursor_t      pos_y;
  btn_t         btn_state;
  bound_t       lim_x;
  bound_t       lim_y;
  cursor_word_t cursor_word_q[$];

  function automatic cursor_t move_clamp(cursor_t pos, int delta, bound_t bnd);
    int v;
    int hi;
    v  = int'(pos) + delta;
    hi = (bnd == '0) ? 0 : int'(bnd) - 1;
    if (v < 0) return '0;
    if (v > hi) return cursor_t'(hi);
    return cursor_t'(v);
  endfunction

  function cursor_word_t track_byte(byte_t b);
    cursor_word_t w;
    byte_t        flags;
    int           dx;
    int           dy;
    flags = pkt_buf[0];
    if (byte_idx == 2'd0 && !b[SYNC_BIT]) begin
      w.st = ST_SKIPPED;
    end else if (byte_idx < 2'd2) begin
      pkt_buf[byte_idx[0]] = b;
      byte_idx = byte_idx + 2'd1;
      w.st = ST_STORED;
    end else begin
      byte_idx = 2'd0;
      if ((flags & OVF_MASK) != '0) begin
        w.st = ST_DROPPED;
      end else begin
        dx = int'(pkt_buf[1]) - (flags[X_SIGN_BIT] ? 256 : 0);
        dy = int'(b) - (flags[Y_SIGN_BIT] ? 256 : 0);
        pos_x = move_clamp(pos_x, dx, lim_x);
        pos_y = move_clamp(pos_y, -dy, lim_y);
        btn_state = flags[BTN_W-1:0];
        w.st = ST_APPLIED;
      end
    end
    w.x   = pos_x;
    w.y   = pos_y;
    w.btn = btn_state;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_word_t w;
    if (!rst_ni) begin
      byte_idx      = 2'd0;
      pkt_buf[0]    = '0;
      pkt_buf[1]    = '0;
      pos_x         = cursor_t'(POS_X_RESET);
      pos_y         = cursor_t'(POS_Y_RESET);
      btn_state     = '0;
      lim_x         = BOUND_X_RESET;
      lim_y         = BOUND_Y_RESET;
      cursor_word_q.delete();
      err_cnt_o     = 0;
      outstanding_o = 0;
      words_o       = 0;
      applied_o     = 0;
      dropped_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_BOUND_X: lim_x = cfg_data_i;
          CFG_BOUND_Y: lim_y = cfg_data_i;
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) begin
        cursor_word_q.push_back(track_byte(byte_mon.rx_byte));
      end
      if (cursor_mon.valid && cursor_mon.ready) begin
        words_o++;
        if (cursor_word_q.size() == 0) begin
          $error("cursor word with no prediction pending");
          err_cnt_o++;
        end else begin
          w = cursor_word_q.pop_front();
          if (w.st == ST_APPLIED) applied_o++;
          if (w.st == ST_DROPPED) dropped_o++;
          if (cursor_mon.cursor_x !== w.x) begin
            $error("cursor_x mismatch: expected %0d, got %0d", w.x, cursor_mon.cursor_x);
            err_cnt_o++;
          end
          if (cursor_mon.cursor_y !== w.y) begin
            $error("cursor_y mismatch: expected %0d, got %0d", w.y, cursor_mon.cursor_y);
            err_cnt_o++;
          end
          if (cursor_mon.button_bits !== w.btn) begin
            $error("button_bits mismatch: expected %0d, got %0d", w.btn,
                   cursor_mon.button_bits);
            err_cnt_o++;
          end
          if (cursor_mon.status !== w.st) begin
            $error("status mismatch: expected %0d, got %0d", w.st, cursor_mon.status);
            err_cnt_o++;
          end
        end
      end
      outstanding_o = cursor_word_q.size();
    end
  end

endmodule

FILE: bench/ps2_mouse_packet_cursor_tracker_core_tb.sv
`timescale 1ns / 1ps
module ps2_mouse_packet_cursor_tracker_core_tb;
  import ps2m_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 172;
  localparam int NUM_PHASES  = 8;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  bound_t   cfg_data;

  int err_cnt;
  int outstanding;
  int words;
  int applied;
  int dropped;

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int quiet;

  ps2m_byte_if   byte_ch ();
  ps2m_cursor_if cursor_ch ();

  ps2_mouse_packet_cursor_tracker_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (byte_ch),
    .out_ch     (cursor_ch)
  );

  ps2m_cursor_scoreboard scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .byte_mon      (byte_ch),
    .cursor_mon    (cursor_ch),
    .err_cnt_o     (err_cnt),
    .outstanding_o (outstanding),
    .words_o       (words),
    .applied_o     (applied),
    .dropped_o     (dropped)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // stall the cursor port; a requested hold-off overrides random stalls
  initial begin
    logic next_ready;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        next_ready = 1'b0;
        hold_left--;
      end else begin
        next_ready = ($urandom_range(99) >= stall_pct);
      end
      @(negedge clk);
      cursor_ch.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (cursor_ch.valid && cursor_ch.ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_byte(input byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic drain_cursor_words();
    byte_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_bounds(input bound_t bx, input bound_t by);
    cfg_we   <= 1'b1;
    cfg_idx  <= cfg_idx_t'(CFG_BOUND_X);
    cfg_data <= bx;
    @(negedge clk);
    cfg_idx  <= cfg_idx_t'(CFG_BOUND_Y);
    cfg_data <= by;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // mostly well-formed packets, some with overflow flags, the rest loose bytes
  task automatic push_random_packet(inout int sent);
    byte_t head;
    if ($urandom_range(99) < 88) begin
      head = byte_t'($urandom_range(255));
      head[SYNC_BIT] = 1'b1;
      if ($urandom_range(99) < 85) head = head & ~OVF_MASK;
      push_byte(head);
      push_byte(byte_t'($urandom_range(255)));
      push_byte(byte_t'($urandom_range(255)));
      sent += 3;
    end else begin
      push_byte(byte_t'($urandom_range(255)));
      sent++;
    end
  endtask

  initial begin
    byte_t  directed [] = '{8'h00, 8'hF7,
                            8'h09, 8'hFF, 8'h01,
                            8'h3F, 8'h00, 8'h00,
                            8'h4A, 8'h12, 8'h34,
                            8'hFF, 8'hFF, 8'hFF,
                            8'h18, 8'h00, 8'h00,
                            8'h18, 8'h00, 8'h00,
                            8'h18, 8'h00, 8'h00,
                            8'h2E, 8'h00, 8'h00};
    bound_t bx_set [NUM_PHASES] = '{16'd1280, 16'd1, 16'd65535, 16'd0,
                                    16'd320, 16'd65535, 16'd0, 16'd7};
    bound_t by_set [NUM_PHASES] = '{16'd800, 16'd1, 16'd65535, 16'd0,
                                    16'd240, 16'd2, 16'd0, 16'd5};
    int     sent;
    bit     mid_done;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    byte_ch.valid    = 1'b0;
    byte_ch.rx_byte  = '0;
    cursor_ch.ready  = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_req         = 1'b0;
    quiet            = 0;
    bx_set[6]        = bound_t'($urandom_range(65535));
    by_set[6]        = bound_t'($urandom_range(65535));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) push_byte(directed[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_cursor_words();
        write_bounds(bx_set[p], by_set[p]);
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      sent     = 0;
      mid_done = 1'b0;
      while (sent < PHASE_BYTES) begin
        if (!mid_done && sent >= PHASE_BYTES / 2) begin
          mid_done = 1'b1;
          if (p == 4) hold_req = 1'b1;
          if (p == 5) drain_cursor_words();
        end
        push_random_packet(sent);
      end
    end

    drain_cursor_words();
    repeat (10) @(posedge clk);

    $display("Checked %0d cursor words: %0d packets applied, %0d dropped on overflow.",
             words, applied, dropped);
    $display("Bounds swept from 0 to 65535 under idle, stall and long hold-off traffic.");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
